// ----- hdl/build_script_tokenizer_unit_assert.svh -----
// Assertion macros shared by the tokenizer RTL.
// BST_ASSERT checks an invariant; BST_ASSERT_IMP checks an implication in the same cycle.
// Both are masked while aresetn is low.
`ifndef BUILD_SCRIPT_TOKENIZER_UNIT_ASSERT_SVH
`define BUILD_SCRIPT_TOKENIZER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BST_ASSERT(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);
`define BST_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define BST_ASSERT(name, cond, msg)
`define BST_ASSERT_IMP(name, ante, cons, msg)
`endif
`endif

// ----- hdl/bst_pkg.sv -----
`timescale 1ns / 1ps
package bst_pkg;

    localparam int OFF_W  = 20;
    localparam int LINE_W = 16;

    localparam logic [OFF_W-1:0]  OFF_MAX  = '1;
    localparam logic [LINE_W-1:0] LINE_MAX = '1;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // source bytes with a meaning of their own
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_CTRL_MAX = 8'd30;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_WS     = 3'd1,
        MODE_IDENT  = 3'd2,
        MODE_COLON  = 3'd3,
        MODE_STRING = 3'd4
    } scan_mode_t;

    typedef enum logic [3:0] {
        KIND_IDENT   = 4'd0,
        KIND_COLON   = 4'd1,
        KIND_ASSIGN  = 4'd2,
        KIND_EQUALS  = 4'd3,
        KIND_DOLLAR  = 4'd4,
        KIND_LPAREN  = 4'd5,
        KIND_RPAREN  = 4'd6,
        KIND_ERROR   = 4'd7,
        KIND_WS      = 4'd8,
        KIND_STRING  = 4'd9,
        KIND_NEWLINE = 4'd10,
        KIND_EOF     = 4'd11
    } tok_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_UNEXP = 2'd1,
        ERR_UNTERM = 2'd2
    } err_kind_t;

    typedef struct packed {
        tok_kind_t          kind;
        err_kind_t          err;
        logic [OFF_W-1:0]   start;
        logic [OFF_W-1:0]   len;
        logic [LINE_W-1:0]  line;
        logic               last;
    } tok_t;

    // up to two tokens finished by one source byte
    typedef struct packed {
        logic [1:0]     count;
        tok_t [1:0]     tok;
    } scan_res_t;

    function automatic logic is_name_lead(logic [7:0] b);
        return (b inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F});
    endfunction

    function automatic logic is_name_stop(logic [7:0] b);
        return (b <= CH_CTRL_MAX) ||
               (b inside {CH_LT, CH_GT, CH_COLON, CH_QUOTE, CH_PIPE,
                          CH_QMARK, CH_STAR, CH_LPAR, CH_RPAR});
    endfunction

    function automatic tok_t mk_tok(tok_kind_t k, err_kind_t e, logic [OFF_W-1:0] s,
                                    logic [OFF_W-1:0] l, logic [LINE_W-1:0] ln);
        tok_t t;
        t.kind  = k;
        t.err   = e;
        t.start = s;
        t.len   = l;
        t.line  = ln;
        t.last  = 1'b0;
        return t;
    endfunction

endpackage

// ----- hdl/bst_scanner.sv -----
`timescale 1ns / 1ps
`include "build_script_tokenizer_unit_assert.svh"
module bst_scanner import bst_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic        step_op,
    input  logic [7:0]  step_byte,
    output scan_res_t   res_o
);

    scan_mode_t         mode_reg, mode_next;
    logic [OFF_W-1:0]   begin_reg, begin_next;
    logic [OFF_W-1:0]   pos_reg, pos_next;
    logic [LINE_W-1:0]  line_reg, line_next;
    logic               ended_reg, ended_next;

    always_comb begin
        logic       end_c;
        logic       do_idle;
        logic       fin_a, err_a, fin_b, err_b;
        tok_kind_t  kind_a, kind_b;
        logic [1:0] n;
        tok_t [1:0] tok;

        mode_next  = mode_reg;
        begin_next = begin_reg;
        pos_next   = pos_reg;
        line_next  = line_reg;
        ended_next = ended_reg;
        do_idle    = 1'b0;
        fin_a      = 1'b0;
        err_a      = 1'b0;
        fin_b      = 1'b0;
        err_b      = 1'b0;
        kind_a     = KIND_EOF;
        kind_b     = KIND_EOF;
        n          = 2'd0;
        tok        = '0;
        end_c      = step_op | (step_byte == CH_NUL);

        if (ended_reg) begin
            begin_next = pos_reg;
            tok[0]     = mk_tok(KIND_EOF, ERR_NONE, pos_reg, '0, line_reg);
            n          = 2'd1;
        end else begin
            // continue or close the open token
            case (mode_reg)
                MODE_WS: begin
                    if (!end_c && (step_byte == CH_SPACE || step_byte == CH_TAB)) begin
                        pos_next = (pos_next == OFF_MAX) ? pos_next : pos_next + 1'b1;
                    end else begin
                        fin_a   = 1'b1;
                        kind_a  = KIND_WS;
                        do_idle = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (!end_c && !is_name_stop(step_byte)) begin
                        pos_next = (pos_next == OFF_MAX) ? pos_next : pos_next + 1'b1;
                    end else begin
                        fin_a   = 1'b1;
                        kind_a  = KIND_IDENT;
                        do_idle = 1'b1;
                    end
                end
                MODE_COLON: begin
                    if (!end_c && step_byte == CH_EQ) begin
                        pos_next = (pos_next == OFF_MAX) ? pos_next : pos_next + 1'b1;
                        fin_a    = 1'b1;
                        kind_a   = KIND_ASSIGN;
                    end else begin
                        fin_a   = 1'b1;
                        kind_a  = KIND_COLON;
                        do_idle = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (end_c) begin
                        err_a   = 1'b1;
                        do_idle = 1'b1;
                    end else begin
                        if (step_byte == CH_LF) begin
                            line_next = (line_next == LINE_MAX) ? line_next : line_next + 1'b1;
                        end
                        pos_next = (pos_next == OFF_MAX) ? pos_next : pos_next + 1'b1;
                        if (step_byte == CH_QUOTE) begin
                            fin_a  = 1'b1;
                            kind_a = KIND_STRING;
                        end
                    end
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase

            if (err_a) begin
                tok[n[0]]  = mk_tok(KIND_ERROR, ERR_UNTERM, begin_next, '0, line_next);
                n          = n + 2'd1;
                begin_next = pos_next;
            end
            if (fin_a) begin
                tok[n[0]]  = mk_tok(kind_a, ERR_NONE, begin_next, pos_next - begin_next,
                                    line_next);
                n          = n + 2'd1;
                begin_next = pos_next;
                mode_next  = MODE_IDLE;
            end

            // start a new token from this byte
            if (do_idle) begin
                mode_next = MODE_IDLE;
                if (end_c) begin
                    fin_b      = 1'b1;
                    kind_b     = KIND_EOF;
                    ended_next = 1'b1;
                end else begin
                    pos_next = (pos_next == OFF_MAX) ? pos_next : pos_next + 1'b1;
                    case (step_byte)
                        CH_SPACE, CH_TAB: mode_next = MODE_WS;
                        CH_CR:            mode_next = MODE_IDLE;
                        CH_COLON:         mode_next = MODE_COLON;
                        CH_QUOTE:         mode_next = MODE_STRING;
                        CH_EQ: begin
                            fin_b  = 1'b1;
                            kind_b = KIND_EQUALS;
                        end
                        CH_DOLLAR: begin
                            fin_b  = 1'b1;
                            kind_b = KIND_DOLLAR;
                        end
                        CH_LPAR: begin
                            fin_b  = 1'b1;
                            kind_b = KIND_LPAREN;
                        end
                        CH_RPAR: begin
                            fin_b  = 1'b1;
                            kind_b = KIND_RPAREN;
                        end
                        CH_LF: begin
                            line_next = (line_next == LINE_MAX) ? line_next : line_next + 1'b1;
                            fin_b     = 1'b1;
                            kind_b    = KIND_NEWLINE;
                        end
                        default: begin
                            if (is_name_lead(step_byte)) begin
                                mode_next = MODE_IDENT;
                            end else begin
                                err_b = 1'b1;
                            end
                        end
                    endcase
                end
            end

            if (err_b) begin
                tok[n[0]]  = mk_tok(KIND_ERROR, ERR_UNEXP, begin_next, '0, line_next);
                n          = n + 2'd1;
                begin_next = pos_next;
            end
            if (fin_b) begin
                tok[n[0]]  = mk_tok(kind_b, ERR_NONE, begin_next, pos_next - begin_next,
                                    line_next);
                n          = n + 2'd1;
                begin_next = pos_next;
                mode_next  = MODE_IDLE;
            end
        end

        // mark the final token of this byte
        if (n == 2'd2) begin
            tok[1].last = 1'b1;
        end else if (n == 2'd1) begin
            tok[0].last = 1'b1;
        end

        res_o.count = n;
        res_o.tok   = tok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            begin_reg <= '0;
            pos_reg   <= '0;
            line_reg  <= LINE_W'(1);
            ended_reg <= 1'b0;
        end else if (step) begin
            mode_reg  <= mode_next;
            begin_reg <= begin_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            ended_reg <= ended_next;
        end
    end

    `BST_ASSERT(a_begin_le_pos, begin_reg <= pos_reg, "token start beyond current offset")
    `BST_ASSERT(a_line_nonzero, line_reg != '0, "line count dropped to zero")
    `BST_ASSERT_IMP(a_eof_after_end, step && ended_reg, res_o.count == 2'd1 && res_o.tok[0].kind == KIND_EOF && res_o.tok[0].len == '0, "input after end must give one empty eof")

endmodule

// ----- hdl/build_script_tokenizer_unit.sv -----
`timescale 1ns / 1ps
`include "build_script_tokenizer_unit_assert.svh"
// Build script tokenizer: takes one source byte per request on the s_ side (s_tuser high, or a
// zero byte, marks end of source) and returns finished tokens on the m_ side with kind, error
// code, start offset, length and line. A byte is taken every cycle while the four-entry result
// queue has room for two tokens; the scan is combinational from the input register to
// the queue: a token's closing byte is held in the input register, then the token is written
// into the queue and is valid on the m_ side; a full queue can hold the byte back. A byte can
// close two tokens (for example a whitespace run ended by a newline), and the m_ side drains
// one token per cycle, so the sustained rate is one byte per cycle as long as tokens come out
// no faster than that and m_tready stays high; m_tlast marks the last token of each byte.
// After end of source every further request yields one empty eof token.
module build_script_tokenizer_unit import bst_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_req
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [19:0] start_offset, [39:20] token_length,
                                   // [55:40] line_number
    output logic [5:0]  m_tuser,   // [3:0] token_kind, [5:4] error_kind
    output logic        m_tlast
);

    logic               in_valid_reg;
    logic               in_op_reg;
    logic [7:0]         in_byte_reg;

    tok_t               fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               process;
    logic               pop;
    scan_res_t          scan_res;
    tok_t               head;

    assign process  = in_valid_reg && (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign s_tready = !in_valid_reg || process;
    assign pop      = m_tvalid && m_tready;

    bst_scanner u_scanner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (process),
        .step_op   (in_op_reg),
        .step_byte (in_byte_reg),
        .res_o     (scan_res)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // result queue
    always_comb begin
        count_next = count_reg;
        if (process) begin
            count_next = count_next + CNT_W'(scan_res.count);
        end
        if (pop) begin
            count_next = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (process) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(scan_res.count);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (process && scan_res.count != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= scan_res.tok[0];
        end
        if (process && scan_res.count == 2'd2) begin
            fifo_reg[wr_ptr_reg + FIFO_AW'(1)] <= scan_res.tok[1];
        end
    end

    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {head.line, head.len, head.start};
    assign m_tuser  = {head.err, head.kind};
    assign m_tlast  = head.last;

    `BST_ASSERT(a_count_bound, count_reg <= CNT_W'(FIFO_DEPTH), "result queue overflow")
    `BST_ASSERT_IMP(a_room_for_two, process, count_reg + CNT_W'(2) <= CNT_W'(FIFO_DEPTH), "scan step without room for two tokens")

endmodule

// ----- tb/tb_build_script_tokenizer_unit.sv -----
`timescale 1ns / 1ps
module tb_build_script_tokenizer_unit;
    import bst_pkg::*;

    localparam int     HOLD_CYCLES  = 60;
    localparam int     RANDOM_ITEMS = 360;
    localparam int     TAIL_ITEMS   = 30;
    localparam longint TIMEOUT_NS   = 60_000_000;

    typedef struct packed {
        logic [7:0]       ch;
        logic             typed;
        tok_kind_t        kind;
        err_kind_t        err;
        logic [OFF_W-1:0] start;
        logic [OFF_W-1:0] len;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [5:0]  m_tuser;
    logic        m_tlast;

    // tokenizer state as predicted
    scan_mode_t        scan_st;
    logic [OFF_W-1:0]  tok_begin;
    logic [OFF_W-1:0]  byte_pos;
    logic [LINE_W-1:0] line_cnt;
    logic              src_done;

    tok_t     step_toks[$];
    tok_t     token_q[$];
    dir_row_t dir_rows[$];
    tok_t     got_want;

    int   mismatch_cnt = 0;
    int   tokens_seen  = 0;
    int   burst_left   = 0;
    int   items_sent   = 0;
    logic hold_req     = 1'b0;

    build_script_tokenizer_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d tokens still expected", token_q.size());
        $display("Some tests failed");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 100) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("token %0d %s: got %0d, want %0d",
                                    tokens_seen, what, got, want));
        end
    endtask

    // ---------------- token predictor ----------------

    function automatic logic stops_ident(input logic [7:0] ch);
        if (ch <= CH_CTRL_MAX) return 1'b1;
        case (ch)
            CH_LT, CH_GT, CH_COLON, CH_QUOTE, CH_PIPE,
            CH_QMARK, CH_STAR, CH_LPAR, CH_RPAR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic starts_ident(input logic [7:0] ch);
        return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
    endfunction

    function automatic void bump_pos();
        if (byte_pos != OFF_MAX) byte_pos++;
    endfunction

    function automatic void bump_line();
        if (line_cnt != LINE_MAX) line_cnt++;
    endfunction

    function automatic void add_token(input tok_kind_t k, input err_kind_t e,
                                      input logic [OFF_W-1:0] s,
                                      input logic [OFF_W-1:0] l);
        tok_t t;
        t = '0;
        t.kind  = k;
        t.err   = e;
        t.start = s;
        t.len   = l;
        t.line  = line_cnt;
        step_toks.push_back(t);
    endfunction

    function automatic void close_token(input tok_kind_t k);
        add_token(k, ERR_NONE, tok_begin, byte_pos - tok_begin);
        tok_begin = byte_pos;
        scan_st   = MODE_IDLE;
    endfunction

    function automatic void open_token(input logic at_end, input logic [7:0] ch);
        scan_st = MODE_IDLE;
        if (at_end) begin
            close_token(KIND_EOF);
            src_done = 1'b1;
            return;
        end
        bump_pos();
        case (ch)
            CH_SPACE, CH_TAB: scan_st = MODE_WS;
            CH_CR:            ;
            CH_COLON:         scan_st = MODE_COLON;
            CH_QUOTE:         scan_st = MODE_STRING;
            CH_EQ:            close_token(KIND_EQUALS);
            CH_DOLLAR:        close_token(KIND_DOLLAR);
            CH_LPAR:          close_token(KIND_LPAREN);
            CH_RPAR:          close_token(KIND_RPAREN);
            CH_LF: begin
                bump_line();
                close_token(KIND_NEWLINE);
            end
            default: begin
                if (starts_ident(ch)) begin
                    scan_st = MODE_IDENT;
                end else begin
                    add_token(KIND_ERROR, ERR_UNEXP, tok_begin, '0);
                    tok_begin = byte_pos;
                end
            end
        endcase
    endfunction

    function automatic void scan_byte(input logic op, input logic [7:0] ch);
        logic at_end;
        step_toks.delete();
        at_end = op || (ch == CH_NUL);
        if (src_done) begin
            tok_begin = byte_pos;
            add_token(KIND_EOF, ERR_NONE, byte_pos, '0);
        end else begin
            case (scan_st)
                MODE_WS: begin
                    if (!at_end && (ch == CH_SPACE || ch == CH_TAB)) begin
                        bump_pos();
                    end else begin
                        close_token(KIND_WS);
                        open_token(at_end, ch);
                    end
                end
                MODE_IDENT: begin
                    if (!at_end && !stops_ident(ch)) begin
                        bump_pos();
                    end else begin
                        close_token(KIND_IDENT);
                        open_token(at_end, ch);
                    end
                end
                MODE_COLON: begin
                    if (!at_end && ch == CH_EQ) begin
                        bump_pos();
                        close_token(KIND_ASSIGN);
                    end else begin
                        close_token(KIND_COLON);
                        open_token(at_end, ch);
                    end
                end
                MODE_STRING: begin
                    if (at_end) begin
                        add_token(KIND_ERROR, ERR_UNTERM, tok_begin, '0);
                        tok_begin = byte_pos;
                        open_token(1'b1, ch);
                    end else begin
                        if (ch == CH_LF) bump_line();
                        bump_pos();
                        if (ch == CH_QUOTE) close_token(KIND_STRING);
                    end
                end
                default: open_token(at_end, ch);
            endcase
        end
        if (step_toks.size() != 0) step_toks[step_toks.size() - 1].last = 1'b1;
    endfunction

    // ---------------- stimulus ----------------

    function automatic void add_row(input logic [7:0] ch);
        dir_row_t r;
        r = '0;
        r.ch = ch;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_typed(input logic [7:0] ch, input tok_kind_t k,
                                      input err_kind_t e, input logic [OFF_W-1:0] s,
                                      input logic [OFF_W-1:0] l);
        dir_row_t r;
        r = '0;
        r.ch    = ch;
        r.typed = 1'b1;
        r.kind  = k;
        r.err   = e;
        r.start = s;
        r.len   = l;
        dir_rows.push_back(r);
    endfunction

    // Offer one request; insert a random gap between bursts.
    task automatic push_byte(input logic op, input logic [7:0] ch, input logic typed,
                             input tok_t want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = ch;
        do @(posedge aclk); while (!s_tready);
        scan_byte(op, ch);
        if (typed) begin
            token_q.push_back(want);
        end else begin
            foreach (step_toks[i]) token_q.push_back(step_toks[i]);
        end
        if (burst_left != 0) burst_left--;
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send(input logic op, input logic [7:0] ch);
        push_byte(op, ch, 1'b0, '0);
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return "_";
    endfunction

    function automatic logic [7:0] ident_tail();
        int         r;
        logic [7:0] ch;
        r = $urandom_range(0, 9);
        if (r < 5) return rand_letter();
        if (r == 5) return CH_SPACE;
        if (r == 6) return CH_EQ;
        do ch = 8'($urandom_range(31, 255)); while (stops_ident(ch));
        return ch;
    endfunction

    function automatic logic [7:0] string_byte();
        logic [7:0] ch;
        if ($urandom_range(0, 5) == 0) return CH_LF;
        do ch = 8'($urandom_range(1, 255)); while (ch == CH_QUOTE);
        return ch;
    endfunction

    // Mostly well-formed lexemes, with some broken strings and stray bytes.
    task automatic send_lexeme();
        logic [7:0] ch;
        case ($urandom_range(0, 15))
            0, 1, 2: begin
                send(1'b0, rand_letter());
                repeat ($urandom_range(0, 6)) send(1'b0, ident_tail());
            end
            3, 4: repeat ($urandom_range(1, 5)) begin
                send(1'b0, $urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            end
            5: begin
                send(1'b0, CH_QUOTE);
                repeat ($urandom_range(0, 5)) send(1'b0, string_byte());
                if ($urandom_range(0, 7) != 0) send(1'b0, CH_QUOTE);
            end
            6:  send(1'b0, CH_COLON);
            7: begin
                send(1'b0, CH_COLON);
                send(1'b0, CH_EQ);
            end
            8:  send(1'b0, CH_EQ);
            9:  send(1'b0, CH_DOLLAR);
            10: send(1'b0, CH_LPAR);
            11: send(1'b0, CH_RPAR);
            12: send(1'b0, CH_LF);
            13: send(1'b0, CH_CR);
            default: begin
                ch = 8'($urandom_range(1, 255));
                send(1'b0, ch);
            end
        endcase
    endtask

    // ---------------- result side ----------------

    initial begin
        logic [15:0] stall_pat;
        int          pat_left;
        logic [3:0]  pat_idx;
        m_tready  = 1'b0;
        stall_pat = '1;
        pat_left  = 0;
        pat_idx   = '0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            if (pat_left == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pat = '1;
                    1: stall_pat = 16'($urandom);
                    2: stall_pat = 16'($urandom | $urandom);
                    default: stall_pat = 16'h00FF << $urandom_range(0, 8);
                endcase
                pat_left = $urandom_range(16, 96);
            end
            pat_left--;
            m_tready = stall_pat[pat_idx];
            pat_idx++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (token_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected token kind %0d start %0d len %0d",
                                        m_tuser[3:0], m_tdata[19:0], m_tdata[39:20]));
            end else begin
                got_want = token_q.pop_front();
                check_field("kind",   32'(m_tuser[3:0]),   32'(got_want.kind));
                check_field("error",  32'(m_tuser[5:4]),   32'(got_want.err));
                check_field("start",  32'(m_tdata[19:0]),  32'(got_want.start));
                check_field("length", 32'(m_tdata[39:20]), 32'(got_want.len));
                check_field("line",   32'(m_tdata[55:40]), 32'(got_want.line));
                check_field("last",   32'(m_tlast),        32'(got_want.last));
            end
            tokens_seen++;
        end
    end

    // ---------------- test sequence ----------------

    initial begin
        tok_t row_tok;
        logic [7:0] ch;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        scan_st   = MODE_IDLE;
        tok_begin = '0;
        byte_pos  = '0;
        line_cnt  = LINE_W'(1);
        src_done  = 1'b0;

        // single-byte tokens right after reset, then stray bytes at the extremes
        add_typed(CH_EQ, KIND_EQUALS, ERR_NONE,  OFF_W'(0), OFF_W'(1));
        add_typed("~",   KIND_ERROR,  ERR_UNEXP, OFF_W'(1), OFF_W'(0));
        add_typed(8'hFF, KIND_ERROR,  ERR_UNEXP, OFF_W'(2), OFF_W'(0));
        add_typed(8'h01, KIND_ERROR,  ERR_UNEXP, OFF_W'(3), OFF_W'(0));
        add_row(CH_SPACE);
        add_row(CH_TAB);
        add_row(CH_LF);
        add_row(CH_CR);
        // identifier runs over space, '=', byte 31 and 0xFF; byte 30 ends it
        add_row("A");
        add_row(CH_SPACE);
        add_row(CH_EQ);
        add_row(8'h1F);
        add_row(8'hFF);
        add_row(8'h1E);
        add_row("_");
        add_row(CH_LT);
        add_row(CH_COLON);
        add_row(CH_EQ);
        add_row(CH_COLON);
        add_row(CH_DOLLAR);
        add_row(CH_LPAR);
        add_row(CH_RPAR);
        add_row(CH_QUOTE);
        add_row(CH_LF);
        add_row(CH_QUOTE);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i]) begin
            row_tok       = '0;
            row_tok.kind  = dir_rows[i].kind;
            row_tok.err   = dir_rows[i].err;
            row_tok.start = dir_rows[i].start;
            row_tok.len   = dir_rows[i].len;
            row_tok.line  = LINE_W'(1);
            row_tok.last  = 1'b1;
            push_byte(1'b0, dir_rows[i].ch, dir_rows[i].typed, row_tok);
        end

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= RANDOM_ITEMS / 2 && !hold_req && burst_left < 80) begin
                // stall the result side while requests keep coming
                hold_req   = 1'b1;
                burst_left = 80;
                repeat (20) send(1'b0, CH_EQ);
            end
            send_lexeme();
        end

        burst_left = 0;
        repeat (TAIL_ITEMS) send_lexeme();

        // end of source from a random scan state, then requests past the end
        case ($urandom_range(0, 4))
            0: begin
                send(1'b0, CH_QUOTE);
                send(1'b0, rand_letter());
            end
            1: send(1'b0, CH_SPACE);
            2: send(1'b0, rand_letter());
            3: send(1'b0, CH_COLON);
            default: send(1'b0, CH_EQ);
        endcase
        if ($urandom_range(0, 1)) begin
            ch = 8'($urandom_range(0, 255));
            send(1'b1, ch);
        end else begin
            send(1'b0, CH_NUL);
        end
        repeat (6) begin
            ch = 8'($urandom_range(0, 255));
            send(1'($urandom_range(0, 1)), ch);
        end
        s_tvalid = 1'b0;

        while (token_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatch_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
